@@ rtl/core/mhpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Item layouts, operation and status codes, and the link types between the
// sequencer, the heap RAM and the top level.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned ADDR_W = 10;
  localparam int unsigned DATA_W = 32;

  // largest number of entries; entry 0 of the RAM stays unused
  localparam logic [ADDR_W-1:0] CAPACITY = 10'd1023;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [1:0]               status;
    logic [ADDR_W-1:0]        entry_count;
    logic signed [DATA_W-1:0] top_value;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

endpackage

@@ rtl/core/mhpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram: heap storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/mhpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl: heap sequencer
// Runs insert (sift up) and remove (sift down) over the heap RAM, moving a
// hole instead of swapping, and keeps the count and a copy of the root.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  mhpq_pkg::in_item_t                    item,
  input  logic                                  out_free,
  input  logic [mhpq_pkg::DATA_W-1:0]           rdata_a,
  input  logic [mhpq_pkg::DATA_W-1:0]           rdata_b,
  output mhpq_pkg::mem_req_t                    mreq,
  output mhpq_pkg::ctrl_stat_t                  stat,
  output mhpq_pkg::out_item_t                   res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  localparam int unsigned AW = mhpq_pkg::ADDR_W;
  localparam int unsigned DW = mhpq_pkg::DATA_W;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [DW-1:0] top_r;

  logic [AW:0]   left_w;
  logic [AW:0]   right_w;
  logic          right_ok;
  logic          pick_right;
  logic [DW-1:0] child_val;
  logic [AW-1:0] child_pos;

  assign left_w     = {pos_r, 1'b0};
  assign right_w    = {pos_r, 1'b1};
  assign right_ok   = right_w <= {1'b0, cnt_r};
  // left child wins a tie
  assign pick_right = right_ok && ($signed(rdata_b) > $signed(rdata_a));
  assign child_val  = pick_right ? rdata_b : rdata_a;
  assign child_pos  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    st_nxt        = st_r;
    mreq.we       = 1'b0;
    mreq.waddr    = pos_r;
    mreq.wdata    = val_r;
    mreq.raddr_a  = left_w[AW-1:0];
    mreq.raddr_b  = right_w[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt = '0;
          st_nxt  = mhpq_pkg::ST_OK;
          if (item.kind == mhpq_pkg::KIND_INSERT) begin
            if (cnt_r == mhpq_pkg::CAPACITY) begin
              st_nxt    = mhpq_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              pos_nxt   = cnt_r + 1'b1;
              val_nxt   = item.value;
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              st_nxt    = mhpq_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              rem_nxt = top_r;
              cnt_nxt = cnt_r - 1'b1;
              pos_nxt = AW'(1);
              if (cnt_r == AW'(1)) begin
                state_nxt = S_DONE;
              end else begin
                // fetch the last entry, it refills the root
                mreq.raddr_a = cnt_r;
                state_nxt    = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == AW'(1)) begin
          mreq.we   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mreq.raddr_a = {1'b0, pos_r[AW-1:1]};
          state_nxt    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mreq.we = 1'b1;
        if ($signed(rdata_a) < $signed(val_r)) begin
          // move the parent down into the hole
          mreq.wdata = rdata_a;
          pos_nxt    = {1'b0, pos_r[AW-1:1]};
          state_nxt  = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LAST: begin
        val_nxt   = rdata_a;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (left_w > {1'b0, cnt_r}) begin
          mreq.we   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mreq.we = 1'b1;
        if ($signed(child_val) > $signed(val_r)) begin
          // move the larger child up into the hole
          mreq.wdata = child_val;
          pos_nxt    = child_pos;
          state_nxt  = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    st_r  <= st_nxt;
    // shadow the root entry
    if (mreq.we && (mreq.waddr == AW'(1))) begin
      top_r <= mreq.wdata;
    end
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);

  assign res.removed_value = rem_r;
  assign res.status        = st_r;
  assign res.entry_count   = cnt_r;
  assign res.top_value     = (cnt_r != '0) ? top_r : '0;

endmodule

@@ rtl/core/max_heap_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit: binary max-heap of signed 32-bit values
// Insert sifts a new value up, remove takes the root and sifts the last
// entry down; each item gives one result with status, count and new top.
// ----------------------------------------------------------------------------
//  channel  | ports                        | moves
//  ---------+------------------------------+---------------------------------
//  input    | in_valid, in_ready, in_item  | kind and value, one per item
//  result   | out_valid, out_ready, out_item | removed, status, count, top
//
//  One item at a time. Insert climbs and remove descends level by level,
//  each level a RAM read step then a compare step; a failed op goes to the result.
//  Every level waits for the heap RAM's registered read data.
//  Reset clears the count, sequencer state and result valid; the heap RAM needs no clearing pass.
//  The result waits in an output register; a stalled result holds the
//  sequencer in its final state until it is taken.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::out_item_t out_item
);

  mhpq_pkg::mem_req_t                mreq;
  mhpq_pkg::ctrl_stat_t              stat;
  mhpq_pkg::out_item_t               res;
  logic [mhpq_pkg::DATA_W-1:0]       rdata_a;
  logic [mhpq_pkg::DATA_W-1:0]       rdata_b;
  logic                              out_free;
  logic                              out_valid_r, out_valid_nxt;
  mhpq_pkg::out_item_t               out_item_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = stat.idle;

  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && in_ready),
    .item     (in_item),
    .out_free (out_free),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .mreq     (mreq),
    .stat     (stat),
    .res      (res)
  );

  mhpq_ram #(
    .AW (mhpq_pkg::ADDR_W),
    .DW (mhpq_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (mreq.we),
    .waddr   (mreq.waddr),
    .wdata   (mreq.wdata),
    .raddr_a (mreq.raddr_a),
    .raddr_b (mreq.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.done && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && out_free) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // one item in flight: an accepted item closes the input until its result
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == mhpq_pkg::ST_FULL)) |->
      (out_item.entry_count == mhpq_pkg::CAPACITY))
    else $error("full status with count below capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.entry_count == '0)) |->
      (out_item.top_value == '0))
    else $error("empty heap reports a nonzero top");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == mhpq_pkg::ST_EMPTY)) |->
      ((out_item.entry_count == '0) && (out_item.removed_value == '0)))
    else $error("empty status with entries or a removed value");

  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> ((mreq.waddr != '0) && !stat.idle))
    else $error("heap RAM written at entry zero or while idle");

endmodule
